/* hdl/strided_core_slot_picker_macros.svh */
// Assertion macros shared by the slot picker RTL.
`ifndef STRIDED_CORE_SLOT_PICKER_MACROS_SVH
`define STRIDED_CORE_SLOT_PICKER_MACROS_SVH

// Check cons in the same cycle whenever ante holds.
`define SCSP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante holds.
`define SCSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/scsp_pkg.sv */
// Shared constants, types and helper functions of the slot picker.
`default_nettype none

package scsp_pkg;

  localparam int MASK_BITS    = 64;
  localparam int REG_W        = 64;
  localparam int STRIDE_W     = 7;
  localparam int WORKER_W     = 16;
  localparam int CORE_W       = 6;
  localparam int ADDR_W       = 4;

  localparam int CNT_W        = $clog2(MASK_BITS + 1);
  localparam int POS_W        = $clog2(MASK_BITS);
  localparam int CHUNK_W      = 8;
  localparam int CHUNK_OFF_W  = 3;
  localparam int CHUNK_POP_W  = 4;
  localparam int NUM_CHUNKS   = (MASK_BITS + CHUNK_W - 1) / CHUNK_W;
  localparam int CHUNK_IDX_W  = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int EXT_W        = NUM_CHUNKS * CHUNK_W;
  localparam int POS_FULL_W   = CHUNK_IDX_W + CHUNK_OFF_W;
  localparam int DIV_CNT_W    = $clog2(WORKER_W);
  localparam int SUM_W        = ((CNT_W > STRIDE_W) ? CNT_W : STRIDE_W) + 1;

  // Register indexes (byte address = 8 * index)
  localparam logic REG_CORE_MASK   = 1'b0;
  localparam logic REG_SLOT_STRIDE = 1'b1;

  typedef struct packed {
    logic load;
    logic count_step;
    logic div_step;
    logic walk_step;
    logic sel_step;
    logic finish_empty;
  } scsp_cmd_t;

  typedef struct packed {
    logic chunk_last;
    logic cnt_zero;
    logic div_last;
    logic walk_done;
    logic sel_hit;
  } scsp_status_t;

  function automatic logic [CHUNK_POP_W-1:0] pop8(input logic [CHUNK_W-1:0] b);
    logic [CHUNK_POP_W-1:0] n;
    n = '0;
    for (int i = 0; i < CHUNK_W; i++) begin
      n = n + CHUNK_POP_W'(b[i]);
    end
    return n;
  endfunction

  // Position of the n-th set bit (from 0) inside a byte.
  function automatic logic [CHUNK_OFF_W-1:0] nth_bit8(input logic [CHUNK_W-1:0] b,
                                                      input logic [CHUNK_OFF_W-1:0] n);
    logic [CHUNK_POP_W-1:0] seen;
    logic [CHUNK_OFF_W-1:0] pos;
    logic                   hit;
    seen = '0;
    pos  = '0;
    hit  = 1'b0;
    for (int i = 0; i < CHUNK_W; i++) begin
      if (b[i] && !hit) begin
        if (seen == CHUNK_POP_W'(n)) begin
          pos = CHUNK_OFF_W'(i);
          hit = 1'b1;
        end
        seen = seen + 1'b1;
      end
    end
    return pos;
  endfunction

endpackage

`default_nettype wire

/* hdl/strided_core_slot_picker.sv */
// Top level of the strided core slot picker: register port, sequencer and datapath.
`default_nettype none

`include "strided_core_slot_picker_macros.svh"

// Strided core slot picker. Pulse start with worker_index_i while busy is low to
// begin a transaction; busy stays high until the answer is ready. The answer is
// shown on core_index_o / found_o for exactly one cycle with done_o high, and the
// receiver cannot stall it, so capture it then. With t = worker_index mod (number
// of set mask bits), the sequencer runs a byte-wise popcount of the mask, a
// bit-serial remainder that yields t, a slot walk of t stride steps and a
// byte-wise scan for the chosen set bit. An empty mask skips the remainder and
// answers found_o = 0. busy falls in the cycle done_o rises, so the next
// transaction may start there. Write core_mask (address 0x0) and slot_stride
// (address 0x8) over the APB port only while the block is idle.
module strided_core_slot_picker (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // Register port
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire [scsp_pkg::ADDR_W-1:0]         paddr,
  input  wire [scsp_pkg::REG_W-1:0]          pwdata,
  output logic [scsp_pkg::REG_W-1:0]         prdata,
  output logic                               pready,
  // Command channel
  input  wire                                start,
  output logic                               busy,
  input  wire [scsp_pkg::WORKER_W-1:0]       worker_index_i,
  // Result channel
  output logic                               done_o,
  output logic [scsp_pkg::CORE_W-1:0]        core_index_o,
  output logic                               found_o
);

  logic [scsp_pkg::REG_W-1:0]    core_mask_q;
  logic [scsp_pkg::STRIDE_W-1:0] slot_stride_q;
  logic                          reg_wr;
  logic                          reg_sel;

  scsp_pkg::scsp_cmd_t    cmd;
  scsp_pkg::scsp_status_t status;

  // Register index is the 8-byte word address.
  assign reg_sel = paddr[3];
  assign pready  = 1'b1;
  assign reg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_mask_q   <= '0;
      slot_stride_q <= scsp_pkg::STRIDE_W'(1);
    end else if (reg_wr) begin
      unique case (reg_sel)
        scsp_pkg::REG_CORE_MASK:   core_mask_q   <= pwdata;
        scsp_pkg::REG_SLOT_STRIDE: slot_stride_q <= pwdata[scsp_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register.
  always_comb begin
    unique case (reg_sel)
      scsp_pkg::REG_CORE_MASK:   prdata = core_mask_q;
      scsp_pkg::REG_SLOT_STRIDE: prdata = scsp_pkg::REG_W'(slot_stride_q);
      default:                   prdata = '0;
    endcase
  end

  // Sequencer: one transaction at a time.
  scsp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  // Datapath: holds the working values and the registered result.
  scsp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .core_mask_i    (core_mask_q),
    .slot_stride_i  (slot_stride_q),
    .worker_index_i (worker_index_i),
    .done_o         (done_o),
    .core_index_o   (core_index_o),
    .found_o        (found_o)
  );

  // An accepted transaction always keeps the block busy in the next cycle.
  `SCSP_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "busy missing after start")
  // The result strobe comes with the sequencer back in idle.
  `SCSP_ASSERT_SAME(a_done_idle, clk_i, rst_ni, done_o, !busy, "result shown while busy")
  // One result per transaction: the strobe is never held high back to back.
  `SCSP_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, done_o, !done_o, "result strobe repeated")

endmodule

`default_nettype wire

/* hdl/scsp_ctrl.sv */
// Sequencer of the slot picker: count, divide, walk, select.
`default_nettype none

module scsp_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  input  scsp_pkg::scsp_status_t status_i,
  output scsp_pkg::scsp_cmd_t    cmd_o,
  output logic                  busy_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_COUNT = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_SEL   = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd_o.count_step = 1'b1;
        if (status_i.chunk_last) state_d = S_DIV;
      end
      S_DIV: begin
        if (status_i.cnt_zero) begin
          cmd_o.finish_empty = 1'b1;
          state_d            = S_IDLE;
        end else begin
          cmd_o.div_step = 1'b1;
          if (status_i.div_last) state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (status_i.walk_done) state_d = S_SEL;
        else cmd_o.walk_step = 1'b1;
      end
      S_SEL: begin
        cmd_o.sel_step = 1'b1;
        if (status_i.sel_hit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

/* hdl/scsp_dp.sv */
// Datapath of the slot picker: popcount, remainder, slot walk, set-bit select.
`default_nettype none

module scsp_dp (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  scsp_pkg::scsp_cmd_t                 cmd_i,
  output scsp_pkg::scsp_status_t              status_o,
  input  wire [scsp_pkg::REG_W-1:0]           core_mask_i,
  input  wire [scsp_pkg::STRIDE_W-1:0]        slot_stride_i,
  input  wire [scsp_pkg::WORKER_W-1:0]        worker_index_i,
  output logic                                done_o,
  output logic [scsp_pkg::CORE_W-1:0]         core_index_o,
  output logic                                found_o
);

  logic [scsp_pkg::EXT_W-1:0]                           mask_ext;
  logic [scsp_pkg::NUM_CHUNKS-1:0][scsp_pkg::CHUNK_W-1:0] chunks;
  logic [scsp_pkg::CHUNK_W-1:0]                         cur_chunk;
  logic [scsp_pkg::CHUNK_POP_W-1:0]                     cur_pop;

  logic [scsp_pkg::CHUNK_IDX_W-1:0] chunk_q;
  logic [scsp_pkg::CNT_W-1:0]       cnt_q;
  logic [scsp_pkg::CNT_W-1:0]       rem_q;
  logic [scsp_pkg::WORKER_W-1:0]    dividend_q;
  logic [scsp_pkg::DIV_CNT_W-1:0]   div_cnt_q;
  logic [scsp_pkg::CNT_W-1:0]       slot_q;
  logic [scsp_pkg::CNT_W-1:0]       column_q;
  logic [scsp_pkg::CORE_W-1:0]      core_index_q;
  logic                             found_q;
  logic                             done_q;

  logic [scsp_pkg::CNT_W:0]          trial;
  logic [scsp_pkg::CNT_W:0]          trial_sub;
  logic [scsp_pkg::SUM_W-1:0]        walk_sum;
  logic                              walk_wrap;
  logic                              sel_hit;
  logic [scsp_pkg::CHUNK_OFF_W-1:0]  hit_off;
  logic [scsp_pkg::POS_FULL_W-1:0]   pos_full;
  logic [scsp_pkg::POS_W-1:0]        pos;
  logic                              chunk_last;

  assign mask_ext  = scsp_pkg::EXT_W'(core_mask_i[scsp_pkg::MASK_BITS-1:0]);
  assign chunks    = mask_ext;
  assign cur_chunk = chunks[chunk_q];
  assign cur_pop   = scsp_pkg::pop8(cur_chunk);

  assign chunk_last = (chunk_q == scsp_pkg::CHUNK_IDX_W'(scsp_pkg::NUM_CHUNKS - 1));

  // Restoring division: one dividend bit per step, keeping only the remainder.
  assign trial     = {rem_q, dividend_q[scsp_pkg::WORKER_W-1]};
  assign trial_sub = trial - (scsp_pkg::CNT_W + 1)'(cnt_q);

  // Slot walk: wrap to the next column when the slot runs past the end.
  assign walk_sum  = scsp_pkg::SUM_W'(slot_q) + scsp_pkg::SUM_W'(slot_stride_i);
  assign walk_wrap = (walk_sum >= scsp_pkg::SUM_W'(cnt_q));

  // Select: the chosen bit lies in this chunk once the slot drops below its popcount.
  assign sel_hit  = (slot_q < scsp_pkg::CNT_W'(cur_pop));
  assign hit_off  = scsp_pkg::nth_bit8(cur_chunk, slot_q[scsp_pkg::CHUNK_OFF_W-1:0]);
  assign pos_full = {chunk_q, hit_off};
  assign pos      = pos_full[scsp_pkg::POS_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dividend_q <= worker_index_i;
      cnt_q      <= '0;
      chunk_q    <= '0;
      rem_q      <= '0;
      div_cnt_q  <= '0;
      slot_q     <= '0;
      column_q   <= '0;
    end
    if (cmd_i.count_step) begin
      cnt_q   <= scsp_pkg::CNT_W'(cnt_q + scsp_pkg::CNT_W'(cur_pop));
      chunk_q <= chunk_last ? '0 : chunk_q + 1'b1;
    end
    if (cmd_i.div_step) begin
      dividend_q <= dividend_q << 1;
      div_cnt_q  <= div_cnt_q + 1'b1;
      if (trial >= (scsp_pkg::CNT_W + 1)'(cnt_q)) begin
        rem_q <= trial_sub[scsp_pkg::CNT_W-1:0];
      end else begin
        rem_q <= trial[scsp_pkg::CNT_W-1:0];
      end
    end
    if (cmd_i.walk_step) begin
      rem_q <= rem_q - 1'b1;
      if (walk_wrap) begin
        column_q <= column_q + 1'b1;
        slot_q   <= column_q + 1'b1;
      end else begin
        slot_q <= walk_sum[scsp_pkg::CNT_W-1:0];
      end
    end
    if (cmd_i.sel_step) begin
      if (sel_hit) begin
        core_index_q <= scsp_pkg::CORE_W'(pos);
        found_q      <= 1'b1;
      end else begin
        slot_q  <= slot_q - scsp_pkg::CNT_W'(cur_pop);
        chunk_q <= chunk_q + 1'b1;
      end
    end
    if (cmd_i.finish_empty) begin
      core_index_q <= '0;
      found_q      <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.finish_empty | (cmd_i.sel_step & sel_hit);
    end
  end

  assign status_o.chunk_last = chunk_last;
  assign status_o.cnt_zero   = (cnt_q == '0);
  assign status_o.div_last   =
    (div_cnt_q == scsp_pkg::DIV_CNT_W'(scsp_pkg::WORKER_W - 1));
  assign status_o.walk_done  = (rem_q == '0);
  assign status_o.sel_hit    = sel_hit;

  assign done_o       = done_q;
  assign core_index_o = core_index_q;
  assign found_o      = found_q;

endmodule

`default_nettype wire
